### hdl/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

### hdl/ctp_pkg.sv
// types and constants of the countdown timer pool
`timescale 1ns / 1ps
`default_nettype none

package ctp_pkg;

  localparam int MAX_SLOTS = 16;
  localparam int OPCODE_W  = 2;
  localparam int DUR_W     = 32;
  localparam int SLOT_W    = 4;
  localparam int STATUS_W  = 2;
  localparam int MASK_W    = MAX_SLOTS;

  typedef logic [OPCODE_W-1:0] opcode_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam opcode_t OP_TICK    = 2'd0;
  localparam opcode_t OP_START   = 2'd1;
  localparam opcode_t OP_RELEASE = 2'd2;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_RANGE = 2'd2;

  typedef struct packed {
    opcode_t           opcode;
    logic [DUR_W-1:0]  duration;
    logic [SLOT_W-1:0] slot_sel;
  } cmd_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot_out;
    logic [MASK_W-1:0] done_mask;
  } res_t;

endpackage

`default_nettype wire

### hdl/countdown_timer_pool.sv
// countdown timer pool top level: input register, slot array, result register
`timescale 1ns / 1ps
`default_nettype none

// Pool of NUM_SLOTS countdown timers driven by a command stream. opcode on
// s_axis_tuser selects tick, start or release (any other code is a no-op); each
// command beat gives one result beat with status, slot index and the done-flag
// mask after the command. A command beat is held in the input register until
// the result register is free or being read; the slot array then updates and
// the result register loads together. One command per clock is taken for as
// long as the result side is ready: the whole slot array (parallel decrement,
// lowest-free-slot pick, release) updates together with the result register.
module countdown_timer_pool
  import ctp_pkg::*;
#(
  parameter int NUM_SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // duration [31:0], slot_sel [35:32], zero pad [39:36]
  input  wire logic [39:0] s_axis_tdata,
  // opcode [1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status [1:0], slot_out [5:2], done_mask [21:6], zero pad [23:22]
  output logic [23:0]      m_axis_tdata
);

  logic in_valid;
  cmd_t in_cmd;
  logic out_valid;
  res_t out_res;
  res_t res;
  logic advance;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd.opcode   <= s_axis_tuser;
      in_cmd.duration <= s_axis_tdata[31:0];
      in_cmd.slot_sel <= s_axis_tdata[35:32];
    end
    if (advance) begin
      out_res <= res;
    end
  end

  ctp_slots #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_slots (
    .clk(clk),
    .rst(rst),
    .en (advance),
    .cmd(in_cmd),
    .res(res)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_res.done_mask, out_res.slot_out, out_res.status};

  `include "assert_macros.svh"

  // a held command always moves on when the result register is empty
  `ASSERT_ALWAYS(a_advance_when_empty, clk, rst,
    (in_valid && !out_valid) |=> out_valid, "held command did not reach result register")

  // a tick never fails and never names a slot
  `ASSERT_ALWAYS(a_tick_result, clk, rst,
    (advance && in_cmd.opcode == OP_TICK) |=> (out_res.status == ST_OK && out_res.slot_out == '0),
    "tick produced a nonzero status or slot")

  // pool full is only reported for a start
  `ASSERT_NEVER(a_full_only_on_start, clk, rst,
    advance && res.status == ST_FULL && in_cmd.opcode != OP_START,
    "pool full reported for a command other than start")

endmodule

`default_nettype wire

### hdl/ctp_slots.sv
// slot array: counts, done flags, free-slot search and per-command update
`timescale 1ns / 1ps
`default_nettype none

module ctp_slots
  import ctp_pkg::*;
#(
  parameter int NUM_SLOTS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire cmd_t cmd,
  output res_t      res
);

  localparam logic [NUM_SLOTS-1:0] ONE = NUM_SLOTS'(1);

  logic [DUR_W-1:0]     remaining_ticks      [NUM_SLOTS];
  logic [DUR_W-1:0]     remaining_ticks_next [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] done_flags;
  logic [NUM_SLOTS-1:0] done_flags_next;
  logic [NUM_SLOTS-1:0] free;
  logic [NUM_SLOTS-1:0] grant;
  logic                 sel_out_of_range;

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      free[i] = (remaining_ticks[i] == '0) && !done_flags[i];
    end
  end

  // lowest set bit of the free mask
  assign grant = free & (~free + ONE);

  assign sel_out_of_range = {1'b0, cmd.slot_sel} >= (SLOT_W + 1)'(NUM_SLOTS);

  always_comb begin
    remaining_ticks_next = remaining_ticks;
    done_flags_next      = done_flags;
    res.status           = ST_OK;
    res.slot_out         = '0;
    res.done_mask        = '0;
    case (cmd.opcode)
      OP_TICK: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (remaining_ticks[i] != '0) begin
            remaining_ticks_next[i] = remaining_ticks[i] - DUR_W'(1);
            if (remaining_ticks[i] == DUR_W'(1)) begin
              done_flags_next[i] = 1'b1;
            end
          end
        end
      end
      OP_START: begin
        if (|free) begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (grant[i]) begin
              remaining_ticks_next[i] = cmd.duration;
              // zero duration expires on the spot
              if (cmd.duration == '0) begin
                done_flags_next[i] = 1'b1;
              end
              res.slot_out = res.slot_out | SLOT_W'(i);
            end
          end
        end else begin
          res.status = ST_FULL;
        end
      end
      OP_RELEASE: begin
        res.slot_out = cmd.slot_sel;
        if (sel_out_of_range) begin
          res.status = ST_RANGE;
        end else begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (cmd.slot_sel == SLOT_W'(i)) begin
              remaining_ticks_next[i] = '0;
              done_flags_next[i]      = 1'b0;
            end
          end
        end
      end
      default: begin
      end
    endcase
    for (int i = 0; i < NUM_SLOTS; i++) begin
      res.done_mask[i] = done_flags_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        remaining_ticks[i] <= '0;
      end
      done_flags <= '0;
    end else if (en) begin
      remaining_ticks <= remaining_ticks_next;
      done_flags      <= done_flags_next;
    end
  end

endmodule

`default_nettype wire

### tb/sv/tb_countdown_timer_pool.sv
// testbench for the countdown timer pool: directed table, random commands, slot predictor
`timescale 1ns / 1ps

module tb_countdown_timer_pool;
  import ctp_pkg::*;

  localparam int POOL_SLOTS = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int RAND_CMDS = 750;
  localparam int DRAIN_CYCLES = 10;
  localparam int HOLD_CYCLES = 80;
  localparam int TBL_ROWS = 18;
  localparam opcode_t OP_NOP = 2'd3;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;

  countdown_timer_pool #(.NUM_SLOTS(POOL_SLOTS)) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted slot state
  logic [31:0] slot_count [POOL_SLOTS];
  bit          slot_expired [POOL_SLOTS];

  res_t pending_res [$];
  int   n_cmds;
  int   n_directed;
  int   n_results;
  int   n_bad;
  int   n_full;
  int   stall_cycles;
  bit   no_idle;
  bit   hold_done;

  typedef struct packed {
    opcode_t     op;
    logic [31:0] dur;
    logic [3:0]  sel;
    logic [4:0]  rep;
    logic        typed;
    status_t     st;
    logic [3:0]  slot;
    logic [15:0] mask;
  } cmd_row_t;

  // typed rows carry the expected result, the others go through the predictor
  cmd_row_t cmd_tbl [TBL_ROWS] = '{
    '{OP_TICK,    32'h0,        4'd0,  5'd1,  1'b1, ST_OK,   4'd0,  16'h0000},
    '{OP_RELEASE, 32'h0,        4'd15, 5'd1,  1'b1, ST_OK,   4'd15, 16'h0000},
    '{OP_NOP,     32'hFFFFFFFF, 4'd15, 5'd1,  1'b1, ST_OK,   4'd0,  16'h0000},
    '{OP_START,   32'h0,        4'd0,  5'd1,  1'b1, ST_OK,   4'd0,  16'h0001},
    '{OP_START,   32'h1,        4'd0,  5'd1,  1'b1, ST_OK,   4'd1,  16'h0001},
    '{OP_START,   32'hFFFFFFFF, 4'd0,  5'd1,  1'b1, ST_OK,   4'd2,  16'h0001},
    '{OP_TICK,    32'h0,        4'd0,  5'd1,  1'b0, ST_OK,   4'd0,  16'h0000},
    '{OP_RELEASE, 32'h0,        4'd1,  5'd1,  1'b0, ST_OK,   4'd0,  16'h0000},
    '{OP_START,   32'd10,       4'd0,  5'd14, 1'b0, ST_OK,   4'd0,  16'h0000},
    '{OP_START,   32'h5,        4'd0,  5'd1,  1'b1, ST_FULL, 4'd0,  16'h0001},
    '{OP_RELEASE, 32'h0,        4'd2,  5'd1,  1'b0, ST_OK,   4'd0,  16'h0000},
    '{OP_START,   32'hAAAA5555, 4'd0,  5'd1,  1'b0, ST_OK,   4'd0,  16'h0000},
    '{OP_TICK,    32'h0,        4'd0,  5'd10, 1'b0, ST_OK,   4'd0,  16'h0000},
    '{OP_START,   32'h7,        4'd0,  5'd1,  1'b0, ST_OK,   4'd0,  16'h0000},
    '{OP_RELEASE, 32'h0,        4'd0,  5'd1,  1'b0, ST_OK,   4'd0,  16'h0000},
    '{OP_START,   32'h80000000, 4'd0,  5'd1,  1'b0, ST_OK,   4'd0,  16'h0000},
    '{OP_RELEASE, 32'h0,        4'd15, 5'd1,  1'b0, ST_OK,   4'd0,  16'h0000},
    '{OP_TICK,    32'h0,        4'd0,  5'd1,  1'b0, ST_OK,   4'd0,  16'h0000}
  };

  function automatic res_t step_timers(opcode_t op, logic [31:0] dur, logic [3:0] sel);
    res_t r;
    bit   found;
    r.status = ST_OK;
    r.slot_out = '0;
    found = 1'b0;
    case (op)
      OP_TICK: begin
        for (int i = 0; i < POOL_SLOTS; i++) begin
          if (slot_count[i] != 0) begin
            slot_count[i] = slot_count[i] - 1;
            if (slot_count[i] == 0) slot_expired[i] = 1'b1;
          end
        end
      end
      OP_START: begin
        // lowest slot that is neither running nor expired
        for (int i = 0; i < POOL_SLOTS; i++) begin
          if (!found && slot_count[i] == 0 && !slot_expired[i]) begin
            found = 1'b1;
            r.slot_out = i[3:0];
          end
        end
        if (found) begin
          slot_count[r.slot_out] = dur;
          if (dur == 0) slot_expired[r.slot_out] = 1'b1;
        end else begin
          r.status = ST_FULL;
        end
      end
      OP_RELEASE: begin
        r.slot_out = sel;
        if (int'(sel) >= POOL_SLOTS) begin
          r.status = ST_RANGE;
        end else begin
          slot_count[sel] = 0;
          slot_expired[sel] = 1'b0;
        end
      end
      default: ;
    endcase
    r.done_mask = '0;
    for (int i = 0; i < POOL_SLOTS; i++) r.done_mask[i] = slot_expired[i];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_cmd(opcode_t op, logic [31:0] dur, logic [3:0] sel, bit typed,
                          res_t typed_res);
    int   gap;
    res_t want;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, sel, dur};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    want = step_timers(op, dur, sel);
    if (typed) want = typed_res;
    pending_res.push_back(want);
    if (want.status == ST_FULL) n_full++;
    n_cmds++;
    @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin : chk_res
    res_t want;
    res_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      got.status    = m_axis_tdata[1:0];
      got.slot_out  = m_axis_tdata[5:2];
      got.done_mask = m_axis_tdata[21:6];
      if (pending_res.size() == 0) begin
        $error("result beat with nothing expected: tdata %h", m_axis_tdata);
        n_bad++;
      end else begin
        want = pending_res.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status);
          n_bad++;
        end
        if (got.slot_out !== want.slot_out) begin
          $error("slot_out: expected %0d, actual %0d", want.slot_out, got.slot_out);
          n_bad++;
        end
        if (got.done_mask !== want.done_mask) begin
          $error("done_mask: expected %h, actual %h", want.done_mask, got.done_mask);
          n_bad++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side backpressure, with one long hold-off while commands keep coming
  initial begin : sink
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!hold_done && n_results >= 200) begin
        m_axis_tready <= 1'b0;
        for (int i = 0; i < HOLD_CYCLES; i++) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  end

  initial begin : stim
    res_t        row_res;
    opcode_t     op;
    logic [31:0] dur;
    logic [3:0]  sel;
    int          r;
    int          expired_idx [$];
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    n_cmds = 0;
    n_results = 0;
    n_bad = 0;
    n_full = 0;
    stall_cycles = 0;
    no_idle = 1'b0;
    hold_done = 1'b0;
    for (int i = 0; i < POOL_SLOTS; i++) begin
      slot_count[i] = '0;
      slot_expired[i] = 1'b0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int k = 0; k < TBL_ROWS; k++) begin
      row_res.status    = cmd_tbl[k].st;
      row_res.slot_out  = cmd_tbl[k].slot;
      row_res.done_mask = cmd_tbl[k].mask;
      for (int j = 0; j < int'(cmd_tbl[k].rep); j++) begin
        send_cmd(cmd_tbl[k].op, cmd_tbl[k].dur, cmd_tbl[k].sel, cmd_tbl[k].typed, row_res);
      end
    end
    n_directed = n_cmds;

    row_res = '0;
    for (int k = 0; k < RAND_CMDS; k++) begin
      no_idle = (k >= 300 && k < 420);
      dur = $urandom();
      sel = 4'($urandom_range(0, 15));
      r = $urandom_range(0, 99);
      if (r < 35) begin
        op = OP_TICK;
      end else if (r < 70) begin
        op = OP_START;
        // mostly short counts so slots expire, sometimes zero or huge
        r = $urandom_range(0, 99);
        if (r < 10) dur = 0;
        else if (r < 75) dur = $urandom_range(1, 12);
        else if (r < 90) dur = $urandom_range(13, 300);
      end else if (r < 95) begin
        op = OP_RELEASE;
        expired_idx.delete();
        for (int i = 0; i < POOL_SLOTS; i++) if (slot_expired[i]) expired_idx.push_back(i);
        if (expired_idx.size() != 0 && $urandom_range(0, 1) == 1)
          sel = 4'(expired_idx[$urandom_range(0, expired_idx.size() - 1)]);
      end else begin
        op = OP_NOP;
      end
      send_cmd(op, dur, sel, 1'b0, row_res);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_res.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("commands sent: %0d (%0d from the directed table), results checked: %0d",
             n_cmds, n_directed, n_results);
    $display("starts refused on a full pool: %0d, long result-side hold-off done: %0d",
             n_full, hold_done);
    if (n_bad == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
